FILE: design/ptw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types and constants of the page table walker: request and result
// field widths, action codes, status codes and entry bit positions.
// ----------------------------------------------------------------------------
package ptw_pkg;

    localparam int FRAME_W   = 40;
    localparam int VADDR_W   = 48;
    localparam int PHYS_W    = 52;
    localparam int ENTRY_W   = 64;
    localparam int EIDX_W    = 13;
    localparam int LEVEL_W   = 9;
    localparam int STAT_W    = 3;
    localparam int ACT_W     = 2;

    // s_tdata: action, virt_addr, entry_index, entry_value, one pad bit
    localparam int S_DATA_W  = 128;
    // m_tdata: phys_addr, status, one pad bit
    localparam int M_DATA_W  = 56;

    localparam int PRESENT_BIT = 0;
    localparam int HUGE_BIT    = 7;

    typedef logic [ACT_W-1:0]  action_t;
    typedef logic [STAT_W-1:0] status_t;
    typedef logic [1:0]        level_t;

    localparam action_t ACT_TRANSLATE = 2'd0;
    localparam action_t ACT_UNMAP     = 2'd1;
    localparam action_t ACT_WRITE     = 2'd2;
    localparam action_t ACT_NOP       = 2'd3;

    localparam status_t STAT_OK          = 3'd0;
    localparam status_t STAT_NOT_PRESENT = 3'd1;
    localparam status_t STAT_HUGE        = 3'd2;
    localparam status_t STAT_MISALIGNED  = 3'd3;
    localparam status_t STAT_NO_ROOT     = 3'd4;

    localparam level_t LVL_PML4 = 2'd3;
    localparam level_t LVL_PDPT = 2'd2;
    localparam level_t LVL_PD   = 2'd1;
    localparam level_t LVL_PT   = 2'd0;

endpackage
`default_nettype wire

FILE: design/ptw_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_ram
// Generic single-port RAM: one write or one read per cycle, registered read.
// ----------------------------------------------------------------------------
module ptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: design/ptw_frame_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_frame_mod
// Maps a 40-bit frame number to a store page (frame mod PAGES). A power of
// two is a registered mask; other counts reduce eight frame bits per cycle.
// ----------------------------------------------------------------------------
module ptw_frame_mod #(
    parameter int PAGES  = 16,
    parameter int PAGE_W = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [ptw_pkg::FRAME_W-1:0] frame,
    output logic                            done,
    output logic      [PAGE_W-1:0]          page
);
    import ptw_pkg::*;

    localparam bit IS_POW2 = ((PAGES & (PAGES - 1)) == 0);

    generate
        if (IS_POW2)
        begin : g_pow2
            logic              done_reg;
            logic [PAGE_W-1:0] page_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    page_reg <= PAGE_W'(frame & FRAME_W'(PAGES - 1));
                end
            end

            assign done = done_reg;
            assign page = page_reg;
        end
        else
        begin : g_serial
            localparam int STEP_BITS = 8;
            localparam int STEPS     = FRAME_W / STEP_BITS;
            localparam logic [PAGE_W:0] PAGES_V = (PAGE_W+1)'(PAGES);

            logic [FRAME_W-1:0] frame_reg, frame_next;
            logic [PAGE_W-1:0]  rem_reg, rem_next;
            logic [2:0]         cnt_reg, cnt_next;
            logic               busy_reg, busy_next;
            logic               done_reg, done_next;

            always_comb
            begin
                logic [PAGE_W:0]   t;
                logic [PAGE_W-1:0] r;
                r          = rem_reg;
                frame_next = frame_reg;
                rem_next   = rem_reg;
                cnt_next   = cnt_reg;
                busy_next  = busy_reg;
                done_next  = 1'b0;
                if (start)
                begin
                    frame_next = frame;
                    rem_next   = '0;
                    cnt_next   = '0;
                    busy_next  = 1'b1;
                end
                else if (busy_reg)
                begin
                    // restoring reduction, most significant bit first
                    for (int i = 0; i < STEP_BITS; i++)
                    begin
                        t = {r, frame_reg[FRAME_W-1-i]};
                        if (t >= PAGES_V)
                        begin
                            t = t - PAGES_V;
                        end
                        r = t[PAGE_W-1:0];
                    end
                    rem_next   = r;
                    frame_next = frame_reg << STEP_BITS;
                    cnt_next   = cnt_reg + 3'd1;
                    if (cnt_reg == 3'(STEPS - 1))
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                else
                begin
                    busy_reg <= busy_next;
                    done_reg <= done_next;
                    cnt_reg  <= cnt_next;
                end
            end

            always_ff @(posedge clk)
            begin
                frame_reg <= frame_next;
                rem_reg   <= rem_next;
            end

            assign done = done_reg;
            assign page = rem_reg;
        end
    endgenerate

endmodule
`default_nettype wire

FILE: design/page_table_walker_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// page_table_walker_top
// Four-level x86-64 page table walker over an internal entry store.
// Translates, unmaps 4 KiB leaves and loads store words.
//
//   channel  | dir | handshake              | content
//   ---------+-----+------------------------+--------------------------------
//   s_*      | in  | s_tvalid / s_tready    | request: action, va, index, entry
//   m_*      | out | m_tvalid / m_tready    | result: phys_addr, status
//   APB      | in  | psel, penable, pwrite  | root_frame @0x0, root_valid @0x8
//
// A write or trivial request goes to ST_DONE and from there to the output
// register. A walk passes ST_MOD (frame-to-page step, then one store read)
// and ST_CHECK for each level visited; unmap adds a write-back state. With a
// TABLE_PAGES that is not a power of two the frame-to-page step is a serial
// reduction of eight frame bits at a time. The single store port and the
// frame reducer set this sequence. After reset a clearing pass zeroes all
// TABLE_PAGES*512 store words with s_tready low; APB writes are taken
// meanwhile. A stalled output holds the next result in its final state.
// ----------------------------------------------------------------------------
module page_table_walker_top #(
    parameter int TABLE_PAGES = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // action[1:0], virt_addr[49:2], entry_index[62:50], entry_value[126:63]
    input  wire logic [ptw_pkg::S_DATA_W-1:0]  s_tdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // phys_addr[51:0], status[54:52]
    output logic      [ptw_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [3:0]                    paddr,
    input  wire logic [63:0]                   pwdata,
    output logic      [63:0]                   prdata,
    output logic                               pready
);
    import ptw_pkg::*;

    localparam int DEPTH  = TABLE_PAGES * 512;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PAGE_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_MOD   = 7'b0000100,
        ST_CHECK = 7'b0001000,
        ST_WRITE = 7'b0010000,
        ST_DONE  = 7'b0100000,
        ST_SPARE = 7'b1000000
    } state_t;

    // request fields
    action_t              s_action;
    logic [VADDR_W-1:0]   s_virt_addr;
    logic [EIDX_W-1:0]    s_entry_index;
    logic [ENTRY_W-1:0]   s_entry_value;

    assign s_action      = s_tdata[1:0];
    assign s_virt_addr   = s_tdata[49:2];
    assign s_entry_index = s_tdata[62:50];
    assign s_entry_value = s_tdata[126:63];

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [FRAME_W-1:0]   root_frame_reg;
    logic                 root_valid_reg;

    action_t              act_reg, act_next;
    logic [VADDR_W-1:0]   va_reg, va_next;
    level_t               level_reg, level_next;
    logic [ADDR_W-1:0]    slot_reg, slot_next;
    logic [PHYS_W-1:0]    res_phys_reg, res_phys_next;
    status_t              res_status_reg, res_status_next;
    logic [PHYS_W-1:0]    out_phys_reg, out_phys_next;
    status_t              out_status_reg, out_status_next;

    logic                 s_accept;
    logic                 cfg_write;
    logic                 idx_in_range;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic                 mod_start;
    logic [FRAME_W-1:0]   mod_frame;
    logic                 mod_done;
    logic [PAGE_W-1:0]    mod_page;
    logic [LEVEL_W-1:0]   lvl_idx;
    logic [ADDR_W-1:0]    slot_addr;

    assign s_tready     = (state_reg == ST_IDLE);
    assign s_accept     = s_tvalid && s_tready;
    assign idx_in_range = (32'(s_entry_index) < 32'(DEPTH));

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = paddr[3] ? {63'd0, root_valid_reg}
                                : {{(64-FRAME_W){1'b0}}, root_frame_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_frame_reg <= '0;
            root_valid_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (paddr[3])
            begin
                root_valid_reg <= pwdata[0];
            end
            else
            begin
                root_frame_reg <= pwdata[FRAME_W-1:0];
            end
        end
    end

    // ---------------- shared units ----------------
    ptw_frame_mod #(
        .PAGES  (TABLE_PAGES),
        .PAGE_W (PAGE_W)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .frame (mod_frame),
        .done  (mod_done),
        .page  (mod_page)
    );

    ptw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        unique case (level_reg)
            LVL_PML4: lvl_idx = va_reg[47:39];
            LVL_PDPT: lvl_idx = va_reg[38:30];
            LVL_PD:   lvl_idx = va_reg[29:21];
            LVL_PT:   lvl_idx = va_reg[20:12];
            default:  lvl_idx = va_reg[20:12];
        endcase
    end

    assign slot_addr = ADDR_W'({mod_page, lvl_idx});

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        out_valid_next  = out_valid_reg;
        act_next        = act_reg;
        va_next         = va_reg;
        level_next      = level_reg;
        slot_next       = slot_reg;
        res_phys_next   = res_phys_reg;
        res_status_next = res_status_reg;
        out_phys_next   = out_phys_reg;
        out_status_next = out_status_reg;
        ram_we          = 1'b0;
        ram_addr        = slot_reg;
        ram_wdata       = '0;
        mod_start       = 1'b0;
        mod_frame       = root_frame_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    act_next        = s_action;
                    va_next         = s_virt_addr;
                    level_next      = LVL_PML4;
                    res_phys_next   = '0;
                    res_status_next = STAT_OK;
                    state_next      = ST_DONE;
                    priority if (s_action == ACT_WRITE)
                    begin
                        ram_we    = idx_in_range;
                        ram_addr  = ADDR_W'(s_entry_index);
                        ram_wdata = s_entry_value;
                    end
                    else if (s_action == ACT_NOP)
                    begin
                        res_status_next = STAT_OK;
                    end
                    else if (!root_valid_reg)
                    begin
                        res_status_next = STAT_NO_ROOT;
                    end
                    else if (s_action == ACT_UNMAP && s_virt_addr[11:0] != 12'd0)
                    begin
                        res_status_next = STAT_MISALIGNED;
                    end
                    else
                    begin
                        mod_start  = 1'b1;
                        mod_frame  = root_frame_reg;
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                // read is issued in the cycle the page is known
                ram_addr = slot_addr;
                if (mod_done)
                begin
                    slot_next  = slot_addr;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                mod_frame = ram_rdata[51:12];
                if (!ram_rdata[PRESENT_BIT])
                begin
                    res_status_next = STAT_NOT_PRESENT;
                    state_next      = ST_DONE;
                end
                else
                begin
                    unique case (level_reg)
                        LVL_PML4:
                        begin
                            // huge flag is ignored at the top level
                            mod_start  = 1'b1;
                            level_next = LVL_PDPT;
                            state_next = ST_MOD;
                        end
                        LVL_PDPT:
                        begin
                            if (ram_rdata[HUGE_BIT])
                            begin
                                state_next = ST_DONE;
                                if (act_reg == ACT_TRANSLATE)
                                begin
                                    res_phys_next = {ram_rdata[51:30], va_reg[29:0]};
                                end
                                else
                                begin
                                    res_status_next = STAT_HUGE;
                                end
                            end
                            else
                            begin
                                mod_start  = 1'b1;
                                level_next = LVL_PD;
                                state_next = ST_MOD;
                            end
                        end
                        LVL_PD:
                        begin
                            if (ram_rdata[HUGE_BIT])
                            begin
                                state_next = ST_DONE;
                                if (act_reg == ACT_TRANSLATE)
                                begin
                                    res_phys_next = {ram_rdata[51:21], va_reg[20:0]};
                                end
                                else
                                begin
                                    res_status_next = STAT_HUGE;
                                end
                            end
                            else
                            begin
                                mod_start  = 1'b1;
                                level_next = LVL_PT;
                                state_next = ST_MOD;
                            end
                        end
                        default:
                        begin
                            if (act_reg == ACT_TRANSLATE)
                            begin
                                res_phys_next = {ram_rdata[51:12], va_reg[11:0]};
                                state_next    = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_WRITE;
                            end
                        end
                    endcase
                end
            end
            ST_WRITE:
            begin
                // drop the leaf entry
                ram_we     = 1'b1;
                ram_addr   = slot_reg;
                ram_wdata  = '0;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_phys_next   = res_phys_reg;
                    out_status_next = res_status_reg;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        va_reg         <= va_next;
        level_reg      <= level_next;
        slot_reg       <= slot_next;
        res_phys_reg   <= res_phys_next;
        res_status_reg <= res_status_next;
        out_phys_reg   <= out_phys_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_status_reg, out_phys_reg};

endmodule
`default_nettype wire

FILE: design/ptw_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_checker
// Port-level checks on the page table walker, bound to the top level.
// ----------------------------------------------------------------------------
module ptw_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [ptw_pkg::M_DATA_W-1:0]  m_tdata,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready
);
    import ptw_pkg::*;

    status_t           res_status;
    logic [PHYS_W-1:0] res_phys;

    assign res_status = m_tdata[PHYS_W +: STAT_W];
    assign res_phys   = m_tdata[PHYS_W-1:0];

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while walk in progress");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res_status == STAT_OK || res_status == STAT_NOT_PRESENT ||
                      res_status == STAT_HUGE || res_status == STAT_MISALIGNED ||
                      res_status == STAT_NO_ROOT))
        else $error("undefined status code");

    a_phys_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res_status != STAT_OK |-> res_phys == '0)
        else $error("address reported with failing status");

endmodule

bind page_table_walker_top ptw_checker u_ptw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
`default_nettype wire
